// File: sv/spep_pkg.sv
package spep_pkg;

  // field widths
  localparam int COORD_W = 20;
  localparam int TRIG_W  = 16;
  localparam int DIST_W  = 19;
  localparam int CFG_W   = 19;
  localparam int IDX_W   = 3;

  // datapath widths
  localparam int COEF_W   = 2 * TRIG_W;              // product of two sines/cosines
  localparam int PS_W     = TRIG_W + COORD_W;        // trig times coordinate
  localparam int PC_W     = COEF_W + COORD_W;        // coefficient times coordinate
  localparam int SUM_W    = 54;                      // view sums, 36 fractional bits
  localparam int ROUND_SH = 20;                      // 36 -> 16 fractional bits
  localparam int V_W      = SUM_W - ROUND_SH;        // rounded view coordinate
  localparam int NUM_W    = DIST_W + 1 + V_W;        // screen_distance times view x/y
  localparam int NUMX_W   = NUM_W + 1;               // trial subtract width
  localparam int DEN_W    = V_W - 1;                 // positive depth
  localparam int DIV_STEPS = COORD_W;                // quotient bits kept before saturation
  localparam int EYE_SH   = 28;                      // Q8 -> Q36
  localparam int VSH      = TRIG_W - 2;              // Q1.14 scale of single trig terms

  localparam logic signed [COORD_W-1:0] SCREEN_MAX = 20'sh7ffff;
  localparam logic signed [COORD_W-1:0] SCREEN_MIN = 20'sh80000;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_SIN_PHI    = 3'd1,
    REG_COS_PHI    = 3'd2,
    REG_SIN_PSI    = 3'd3,
    REG_COS_PSI    = 3'd4,
    REG_EYE_DIST   = 3'd5,
    REG_SCREEN_DIST = 3'd6
  } cfg_reg_t;

  localparam logic [TRIG_W-1:0] SIN_PHI_RST  = 16'd16384;
  localparam logic [TRIG_W-1:0] COS_PHI_RST  = 16'd0;
  localparam logic [TRIG_W-1:0] SIN_PSI_RST  = 16'd0;
  localparam logic [TRIG_W-1:0] COS_PSI_RST  = 16'd16384;
  localparam logic [DIST_W-1:0] EYE_DIST_RST = 19'd307200;
  localparam logic [DIST_W-1:0] SCR_DIST_RST = 19'd204800;

  // apply quotient sign and clamp to the 20-bit screen range
  function automatic logic signed [COORD_W-1:0] sat_signed(
    input logic [COORD_W-1:0] mag,
    input logic               ovf,
    input logic               neg
  );
    logic signed [COORD_W-1:0] r;
    if (neg) begin
      if (ovf || (mag > COORD_W'(SCREEN_MIN))) r = SCREEN_MIN;
      else r = -mag;
    end else begin
      if (ovf || (mag > COORD_W'(SCREEN_MAX))) r = SCREEN_MAX;
      else r = mag;
    end
    return r;
  endfunction

endpackage

// File: sv/spherical_eye_perspective_project.sv
// channel   | handshake               | payload
// ----------+-------------------------+-------------------------------------------
// in        | in_valid / in_stall     | world_x, world_y, world_z
// out       | out_valid / out_stall   | screen_x, screen_y, depth_invalid
// cfg       | cfg_write               | cfg_index, cfg_data
//
// one transaction per cycle sustained while in_stall is low
// 27 pipeline stages: input register, rotate multiply, sum/round, scale multiply,
// magnitude, overflow check, 20 one-bit restoring divide stages, sign and clamp
// rst clears all valid bits and loads register reset values
// a two-entry output buffer (output register plus skid) parts the sides;
// in_stall is the registered skid-full flag and freezes the whole pipeline
module spherical_eye_perspective_project import spep_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] world_x,
  input  logic signed [COORD_W-1:0] world_y,
  input  logic signed [COORD_W-1:0] world_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] screen_x,
  output logic signed [COORD_W-1:0] screen_y,
  output logic                      depth_invalid
);

  // configuration registers
  logic                     mode;
  logic signed [TRIG_W-1:0] sin_phi, cos_phi, sin_psi, cos_psi;
  logic [DIST_W-1:0]        eye_dist, scr_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= 1'b0;
      sin_phi  <= SIN_PHI_RST;
      cos_phi  <= COS_PHI_RST;
      sin_psi  <= SIN_PSI_RST;
      cos_psi  <= COS_PSI_RST;
      eye_dist <= EYE_DIST_RST;
      scr_dist <= SCR_DIST_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:        mode     <= cfg_data[0];
        REG_SIN_PHI:     sin_phi  <= cfg_data[TRIG_W-1:0];
        REG_COS_PHI:     cos_phi  <= cfg_data[TRIG_W-1:0];
        REG_SIN_PSI:     sin_psi  <= cfg_data[TRIG_W-1:0];
        REG_COS_PSI:     cos_psi  <= cfg_data[TRIG_W-1:0];
        REG_EYE_DIST:    eye_dist <= cfg_data[DIST_W-1:0];
        REG_SCREEN_DIST: scr_dist <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // matrix coefficients, registered products of the configuration registers
  logic signed [COEF_W-1:0] sp_ss, sp_cs, cp_ss, cp_cs;

  always_ff @(posedge clk) begin
    sp_ss <= sin_phi * sin_psi;
    sp_cs <= sin_phi * cos_psi;
    cp_ss <= cos_phi * sin_psi;
    cp_cs <= cos_phi * cos_psi;
  end

  // pipeline advance, frozen while the skid entry is occupied
  logic skid_full;
  logic en;
  assign en       = !skid_full;
  assign in_stall = skid_full;

  // stage 0: input register
  logic                      v0;
  logic signed [COORD_W-1:0] x0, y0, z0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
    if (en) begin
      x0 <= world_x;
      y0 <= world_y;
      z0 <= world_z;
    end
  end

  // stage 1: rotation products
  logic                      v1;
  logic signed [COORD_W-1:0] x1, y1;
  logic signed [PS_W-1:0]    p_cswx, p_sswz, p_spwy, p_cpwy;
  logic signed [PC_W-1:0]    p_cpss_wx, p_cpcs_wz, p_spss_wx, p_spcs_wz;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
    if (en) begin
      x1        <= x0;
      y1        <= y0;
      p_cswx    <= cos_psi * x0;
      p_sswz    <= sin_psi * z0;
      p_spwy    <= sin_phi * y0;
      p_cpwy    <= cos_phi * y0;
      p_cpss_wx <= cp_ss * x0;
      p_cpcs_wz <= cp_cs * z0;
      p_spss_wx <= sp_ss * x0;
      p_spcs_wz <= sp_cs * z0;
    end
  end

  // stage 2: view sums with rounding offset
  logic                      v2;
  logic signed [COORD_W-1:0] x2, y2;
  logic signed [SUM_W-1:0]   sum_x, sum_y, sum_z;
  logic signed [SUM_W-1:0]   rnd, eye_term, sx_c, sy_c, sz_c;

  always_comb begin
    rnd      = SUM_W'(1) << (ROUND_SH - 1);
    eye_term = SUM_W'(eye_dist) << EYE_SH;
    sx_c = ((SUM_W'(p_cswx) - SUM_W'(p_sswz)) <<< VSH) + rnd;
    sy_c = (SUM_W'(p_spwy) <<< VSH) - SUM_W'(p_cpss_wx) - SUM_W'(p_cpcs_wz) + rnd;
    sz_c = eye_term - SUM_W'(p_spss_wx) - (SUM_W'(p_cpwy) <<< VSH)
           - SUM_W'(p_spcs_wz) + rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      x2    <= x1;
      y2    <= y1;
      sum_x <= sx_c;
      sum_y <= sy_c;
      sum_z <= sz_c;
    end
  end

  // stage 3: floor shift, depth check, scale by screen distance
  logic                     v3, bad3;
  logic signed [NUM_W-1:0]  num_x, num_y;
  logic [DEN_W-1:0]         den3;
  logic signed [V_W-1:0]    vx, vy, vz;
  logic signed [DIST_W:0]   dist_s;
  logic                     vz_pos;

  always_comb begin
    vx     = sum_x[SUM_W-1:ROUND_SH];
    vy     = sum_y[SUM_W-1:ROUND_SH];
    vz     = sum_z[SUM_W-1:ROUND_SH];
    dist_s = {1'b0, scr_dist};
    vz_pos = !vz[V_W-1] && (vz != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      if (mode) begin
        // orthographic: divide the world coordinate by one
        num_x <= NUM_W'(x2);
        num_y <= NUM_W'(y2);
        den3  <= DEN_W'(1);
        bad3  <= 1'b0;
      end else if (!vz_pos) begin
        num_x <= '0;
        num_y <= '0;
        den3  <= DEN_W'(1);
        bad3  <= 1'b1;
      end else begin
        num_x <= dist_s * vx;
        num_y <= dist_s * vy;
        den3  <= vz[DEN_W-1:0];
        bad3  <= 1'b0;
      end
    end
  end

  // stage 4: magnitudes and signs
  logic                v4, bad4, neg_x4, neg_y4;
  logic [NUM_W-1:0]    mag_x4, mag_y4;
  logic [DEN_W-1:0]    den4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      bad4   <= bad3;
      den4   <= den3;
      neg_x4 <= num_x[NUM_W-1];
      neg_y4 <= num_y[NUM_W-1];
      mag_x4 <= num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
      mag_y4 <= num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
    end
  end

  // stage 5: quotient overflow check, seeds the divide chain
  logic                 dv    [0:DIV_STEPS];
  logic                 dbad  [0:DIV_STEPS];
  logic                 dneg_x[0:DIV_STEPS];
  logic                 dneg_y[0:DIV_STEPS];
  logic                 dovf_x[0:DIV_STEPS];
  logic                 dovf_y[0:DIV_STEPS];
  logic [DEN_W-1:0]     dden  [0:DIV_STEPS];
  logic [NUM_W-1:0]     rem_x [0:DIV_STEPS];
  logic [NUM_W-1:0]     rem_y [0:DIV_STEPS];
  logic [COORD_W-1:0]   q_x   [0:DIV_STEPS];
  logic [COORD_W-1:0]   q_y   [0:DIV_STEPS];
  logic [NUM_W-1:0]     den_lim;

  assign den_lim = NUM_W'(den4) << DIV_STEPS;

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= v4;
    if (en) begin
      dbad[0]   <= bad4;
      dneg_x[0] <= neg_x4;
      dneg_y[0] <= neg_y4;
      dovf_x[0] <= mag_x4 >= den_lim;
      dovf_y[0] <= mag_y4 >= den_lim;
      dden[0]   <= den4;
      rem_x[0]  <= mag_x4;
      rem_y[0]  <= mag_y4;
      q_x[0]    <= '0;
      q_y[0]    <= '0;
    end
  end

  // stages 6..25: restoring divide, one quotient bit per stage, msb first
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - k;
    logic [NUMX_W-1:0] dsh, trial_x, trial_y;

    always_comb begin
      dsh     = NUMX_W'(dden[k]) << SH;
      trial_x = {1'b0, rem_x[k]} - dsh;
      trial_y = {1'b0, rem_y[k]} - dsh;
    end

    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (en) dv[k+1] <= dv[k];
      if (en) begin
        dbad[k+1]   <= dbad[k];
        dneg_x[k+1] <= dneg_x[k];
        dneg_y[k+1] <= dneg_y[k];
        dovf_x[k+1] <= dovf_x[k];
        dovf_y[k+1] <= dovf_y[k];
        dden[k+1]   <= dden[k];
        rem_x[k+1]  <= trial_x[NUM_W] ? rem_x[k] : trial_x[NUM_W-1:0];
        rem_y[k+1]  <= trial_y[NUM_W] ? rem_y[k] : trial_y[NUM_W-1:0];
        q_x[k+1]    <= q_x[k] | (trial_x[NUM_W] ? '0 : (COORD_W'(1) << SH));
        q_y[k+1]    <= q_y[k] | (trial_y[NUM_W] ? '0 : (COORD_W'(1) << SH));
      end
    end
  end

  // stage 26: sign and clamp
  logic                      vf, bad_f;
  logic signed [COORD_W-1:0] sx_f, sy_f;

  always_ff @(posedge clk) begin
    if (rst) vf <= 1'b0;
    else if (en) vf <= dv[DIV_STEPS];
    if (en) begin
      bad_f <= dbad[DIV_STEPS];
      sx_f  <= sat_signed(q_x[DIV_STEPS], dovf_x[DIV_STEPS], dneg_x[DIV_STEPS]);
      sy_f  <= sat_signed(q_y[DIV_STEPS], dovf_y[DIV_STEPS], dneg_y[DIV_STEPS]);
    end
  end

  // output register and skid entry
  logic                      push, pop;
  logic signed [COORD_W-1:0] sk_x, sk_y;
  logic                      sk_bad;

  assign push = en && vf;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (pop) begin
        skid_full <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) skid_full <= 1'b1;
      else out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (pop) begin
        screen_x      <= sk_x;
        screen_y      <= sk_y;
        depth_invalid <= sk_bad;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        sk_x   <= sx_f;
        sk_y   <= sy_f;
        sk_bad <= bad_f;
      end else begin
        screen_x      <= sx_f;
        screen_y      <= sy_f;
        depth_invalid <= bad_f;
      end
    end
  end

endmodule

// File: tb/sv/spherical_eye_perspective_project_test.sv
module spherical_eye_perspective_project_test;
  import spep_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 20;
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 20'sh7ffff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 20'sh80000;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic                      bad;
  } screen_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] world_x = '0;
  logic signed [COORD_W-1:0] world_y = '0;
  logic signed [COORD_W-1:0] world_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] screen_x;
  logic signed [COORD_W-1:0] screen_y;
  logic depth_invalid;

  // view settings as the block should hold them
  logic                     mode_q;
  logic signed [TRIG_W-1:0] sin_phi_q, cos_phi_q, sin_psi_q, cos_psi_q;
  logic [DIST_W-1:0]        eye_dist_q, screen_dist_q;

  screen_point_t pending_points[$];
  screen_point_t oldest_point;
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  spherical_eye_perspective_project dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .world_x(world_x), .world_y(world_y), .world_z(world_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .screen_x(screen_x), .screen_y(screen_y), .depth_invalid(depth_invalid)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // clamp a quotient to the screen range
  function automatic logic signed [COORD_W-1:0] clamp_screen(input longint q);
    if (q > longint'(SCREEN_MAX)) return SCREEN_MAX;
    if (q < longint'(SCREEN_MIN)) return SCREEN_MIN;
    return q[COORD_W-1:0];
  endfunction

  // rotate into view space, then perspective divide or orthographic pass
  function automatic screen_point_t project_point(
    input logic signed [COORD_W-1:0] wx, wy, wz
  );
    longint x, y, z, sp, cp, ss, cs, eye, scr, vx, vy, vz;
    screen_point_t r;
    r = '0;
    x = wx;
    y = wy;
    z = wz;
    if (mode_q) begin
      r.sx = wx;
      r.sy = wy;
    end else begin
      sp = sin_phi_q;
      cp = cos_phi_q;
      ss = sin_psi_q;
      cs = cos_psi_q;
      eye = eye_dist_q;
      scr = screen_dist_q;
      vx = (cs * x - ss * z) * 16384;
      vy = -(cp * ss) * x + sp * y * 16384 - (cp * cs) * z;
      vz = -(sp * ss) * x - cp * y * 16384 - (sp * cs) * z + (eye <<< 28);
      // 36 to 16 fractional bits, round half up
      vx = (vx + (64'sd1 <<< 19)) >>> 20;
      vy = (vy + (64'sd1 <<< 19)) >>> 20;
      vz = (vz + (64'sd1 <<< 19)) >>> 20;
      if (vz <= 0) begin
        r.bad = 1'b1;
      end else begin
        r.sx = clamp_screen((scr * vx) / vz);
        r.sy = clamp_screen((scr * vy) / vz);
      end
    end
    return r;
  endfunction

  // receiver: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      if (error_count < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // compare each output transaction with the oldest predicted point
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got x=%0d y=%0d bad=%0b",
                   $time, screen_x, screen_y, depth_invalid);
        error_count++;
      end else begin
        oldest_point = pending_points.pop_front();
        check_field("screen_x", oldest_point.sx, screen_x);
        check_field("screen_y", oldest_point.sy, screen_y);
        check_field("depth_invalid", oldest_point.bad, depth_invalid);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // offer one point; called at a falling edge, returns at a falling edge with valid high
  task automatic send_point(input logic signed [COORD_W-1:0] wx, wy, wz);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    world_x <= wx;
    world_y <= wy;
    world_z <= wz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_points.push_back(project_point(wx, wy, wz));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_points.size() > 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MODE: mode_q = data[0];
      REG_SIN_PHI: sin_phi_q = data[TRIG_W-1:0];
      REG_COS_PHI: cos_phi_q = data[TRIG_W-1:0];
      REG_SIN_PSI: sin_psi_q = data[TRIG_W-1:0];
      REG_COS_PSI: cos_psi_q = data[TRIG_W-1:0];
      REG_EYE_DIST: eye_dist_q = data[DIST_W-1:0];
      REG_SCREEN_DIST: screen_dist_q = data[DIST_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // reprogram every register once the pipeline is empty
  task automatic set_view(
    input logic mode,
    input logic signed [TRIG_W-1:0] sp, cp, ss, cs,
    input logic [DIST_W-1:0] eye, scr
  );
    wait_drained();
    write_reg(REG_MODE, CFG_W'(mode));
    write_reg(REG_SIN_PHI, CFG_W'(sp));
    write_reg(REG_COS_PHI, CFG_W'(cp));
    write_reg(REG_SIN_PSI, CFG_W'(ss));
    write_reg(REG_COS_PSI, CFG_W'(cs));
    write_reg(REG_EYE_DIST, CFG_W'(eye));
    write_reg(REG_SCREEN_DIST, scr);
  endtask

  function automatic logic signed [TRIG_W-1:0] rand_trig();
    if ($urandom_range(9) == 0) return TRIG_W'($urandom);
    return TRIG_W'(int'($urandom_range(32768)) - 16384);
  endfunction

  // mix of extremes, full-range and near-origin coordinates
  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3, 4, 5: return COORD_W'($urandom);
      default: return COORD_W'(int'($urandom_range(131072)) - 65536);
    endcase
  endfunction

  task automatic randomize_view();
    logic [DIST_W-1:0] eye;
    if ($urandom_range(1)) eye = DIST_W'($urandom);
    else eye = DIST_W'($urandom_range(524287, 131072));
    set_view($urandom_range(4) == 0, rand_trig(), rand_trig(), rand_trig(), rand_trig(),
             eye, DIST_W'($urandom));
  endtask

  // reset values: plain front view, depth limits and saturation
  task automatic test_reset_view();
    send_point('0, '0, '0);
    send_point(20'sd25600, -20'sd12800, 20'sd1000);
    send_point(COORD_MAX, COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MIN, 20'sd307199);
    send_point(COORD_MIN, COORD_MAX, 20'sd307199);
    send_point(20'sd5, 20'sd5, 20'sd307200);
    send_point(20'sd5, -20'sd5, COORD_MAX);
  endtask

  // orthographic mode passes x and y even where depth would be bad
  task automatic test_orthographic();
    set_view(1'b1, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 19'd307200, 19'd204800);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX);
    send_point(COORD_MIN, COORD_MAX, 20'sd307200);
    send_point(-20'sd1, 20'sd1, '0);
  endtask

  // out-of-range trig values and distance extremes
  task automatic test_register_extremes();
    set_view(1'b0, -16'sd32768, 16'sd32767, 16'sd16384, -16'sd16384, 19'h7ffff, 19'h7ffff);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(20'sd256, -20'sd256, 20'sd512);
    set_view(1'b0, -16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384, 19'd0, 19'd0);
    send_point(20'sd1000, 20'sd2000, COORD_MIN);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX);
    set_view(1'b0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 19'd1, 19'h7ffff);
    send_point(COORD_MAX, COORD_MIN, -20'sd1);
    send_point(20'sd3, -20'sd3, '0);
  endtask

  // writes to the unused register index must change nothing
  task automatic test_spare_index();
    wait_drained();
    write_reg(REG_SPARE, '1);
    send_point(20'sd4096, -20'sd4096, 20'sd256);
    send_point(COORD_MIN, COORD_MAX, '0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 35 == 0) randomize_view();
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // long receiver hold fills the pipeline, then a pause until all results are out
  task automatic test_backpressure();
    set_view(1'b0, 16'sd11585, 16'sd11585, 16'sd8192, 16'sd14189, 19'd400000, 19'd150000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 200;
    for (int i = 0; i < 60; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    wait_drained();
    for (int i = 0; i < 20; i++) send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    mode_q = 1'b0;
    sin_phi_q = SIN_PHI_RST;
    cos_phi_q = COS_PHI_RST;
    sin_psi_q = SIN_PSI_RST;
    cos_psi_q = COS_PSI_RST;
    eye_dist_q = EYE_DIST_RST;
    screen_dist_q = SCR_DIST_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_view();
    test_orthographic();
    test_register_extremes();
    test_spare_index();
    test_random_traffic(0, 0, 140);
    test_random_traffic(52, 0, 140);
    test_random_traffic(0, 52, 140);
    test_random_traffic(35, 35, 140);
    test_backpressure();

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
sv/spep_pkg.sv
sv/spherical_eye_perspective_project.sv
tb/sv/spherical_eye_perspective_project_test.sv
